### rtl/core/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg
// Shared types and constants of the segmentation argmax class tracker.
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int ScoreWidth = 32;
  localparam int IndexWidth = 8;
  localparam int CountWidth = 9;

  localparam logic [CountWidth-1:0] CountReset = CountWidth'(21);

  typedef logic signed [ScoreWidth-1:0] score_t;
  typedef logic [IndexWidth-1:0]        label_t;
  typedef logic [CountWidth-1:0]        count_t;

  // Beat from the argmax stage to the presence stage. A beat is sent when a
  // pixel completes, when a frame starts, or both.
  typedef struct packed {
    logic   pixel;
    logic   clear;
    label_t index;
  } pixel_beat_t;

endpackage

### rtl/core/sact_if.sv
// ----------------------------------------------------------------------------
// sact_score_if / sact_mask_if
// Valid/ready channels for class scores in and mask bytes out.
// ----------------------------------------------------------------------------
interface sact_score_if import sact_pkg::*;;
  logic   valid;
  logic   ready;
  score_t score;
  logic   frame_start;

  modport source (output valid, output score, output frame_start, input ready);
  modport sink (input valid, input score, input frame_start, output ready);
endinterface

interface sact_mask_if import sact_pkg::*;;
  logic   valid;
  logic   ready;
  label_t label;
  logic   new_class;

  modport source (output valid, output label, output new_class, input ready);
  modport sink (input valid, input label, input new_class, output ready);
endinterface

### rtl/core/sact_argmax.sv
// ----------------------------------------------------------------------------
// sact_argmax
// Input register and running per-pixel maximum over the channel scores.
// ----------------------------------------------------------------------------
module sact_argmax import sact_pkg::*; #(
  parameter int MAX_CLASSES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  count_t             channel_count,
  sact_score_if.sink         scores,
  output logic               beat_valid,
  output pixel_beat_t        beat,
  input  logic               beat_ready
);

  localparam count_t MaxCount = CountWidth'(MAX_CLASSES);

  logic         ir_valid;
  score_t       ir_score;
  logic         ir_frame_start;

  score_t       best_score;
  label_t       best_index;
  label_t       channel_counter;

  count_t       count_eff;
  score_t       cur_best;
  label_t       cur_index;
  label_t       cur_counter;
  logic         greater;
  label_t       index_next;
  logic         last;
  logic         need_beat;
  logic         consume;

  always_comb begin
    if (channel_count == '0) begin
      count_eff = CountWidth'(1);
    end else if (channel_count > MaxCount) begin
      count_eff = MaxCount;
    end else begin
      count_eff = channel_count;
    end
    cur_best    = ir_frame_start ? '0 : best_score;
    cur_index   = ir_frame_start ? '0 : best_index;
    cur_counter = ir_frame_start ? '0 : channel_counter;
    greater     = ir_score > cur_best;
    index_next  = greater ? cur_counter : cur_index;
    last        = ({1'b0, cur_counter} + count_t'(1)) >= count_eff;
    need_beat   = last || ir_frame_start;
    consume     = ir_valid && (!need_beat || beat_ready);
  end

  assign scores.ready = !ir_valid || consume;
  assign beat_valid   = ir_valid && need_beat;
  assign beat.pixel   = last;
  assign beat.clear   = ir_frame_start;
  assign beat.index   = index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid        <= 1'b0;
      best_score      <= '0;
      best_index      <= '0;
      channel_counter <= '0;
    end else begin
      if (scores.ready) begin
        ir_valid <= scores.valid;
      end
      if (consume) begin
        if (last) begin
          best_score      <= '0;
          best_index      <= '0;
          channel_counter <= '0;
        end else begin
          best_score      <= greater ? ir_score : cur_best;
          best_index      <= index_next;
          channel_counter <= cur_counter + label_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scores.valid && scores.ready) begin
      ir_score       <= scores.score;
      ir_frame_start <= scores.frame_start;
    end
  end

endmodule

### rtl/core/sact_presence.sv
// ----------------------------------------------------------------------------
// sact_presence
// Per-frame class presence bitmap and the mask output register.
// ----------------------------------------------------------------------------
module sact_presence import sact_pkg::*; #(
  parameter int MAX_CLASSES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        beat_valid,
  input  pixel_beat_t beat,
  output logic        beat_ready,
  sact_mask_if.source mask
);

  localparam int SelWidth = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  logic [MAX_CLASSES-1:0] seen;
  logic [MAX_CLASSES-1:0] seen_next;
  logic                   seen_bit;
  logic                   is_new;
  logic                   take;
  logic                   o_valid;
  label_t                 o_label;
  logic                   o_new_class;

  assign beat_ready = !o_valid || mask.ready;
  assign take       = beat_valid && beat_ready;

  always_comb begin
    seen_bit  = beat.clear ? 1'b0 : seen[beat.index[SelWidth-1:0]];
    is_new    = (beat.index != '0) && !seen_bit;
    seen_next = beat.clear ? '0 : seen;
    if (beat.pixel && (beat.index != '0)) begin
      seen_next[beat.index[SelWidth-1:0]] = 1'b1;
    end
  end

  assign mask.valid     = o_valid;
  assign mask.label     = o_label;
  assign mask.new_class = o_new_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (take) begin
        seen <= seen_next;
      end
      if (take && beat.pixel) begin
        o_valid <= 1'b1;
      end else if (mask.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && beat.pixel) begin
      o_label     <= beat.index;
      o_new_class <= is_new;
    end
  end

endmodule

### rtl/core/segmentation_argmax_class_tracker.sv
// ----------------------------------------------------------------------------
// segmentation_argmax_class_tracker
// Per-pixel channel argmax with per-frame class presence tracking.
// ----------------------------------------------------------------------------
// Class scores enter one per beat, channel-minor, channel_count scores to a
// pixel, and one mask beat leaves per completed pixel carrying the index of
// the first highest-scoring channel (zero if no score is above zero), plus a flag
// for the first appearance of a nonzero class in the frame. One score is
// taken every cycle unless a beat is held back by the mask output; the
// compare against the running maximum is combinational. A mask beat is
// formed from the last score of its pixel in the input register and then
// registered in the mask output register; it waits while an earlier mask
// beat is still waiting, and while one waits, scores that neither complete a pixel nor start a frame keep flowing.
// A score with frame_start high clears the presence bitmap and starts a fresh
// pixel. Write channel_count only while the block is idle.
// ----------------------------------------------------------------------------
module segmentation_argmax_class_tracker import sact_pkg::*; #(
  parameter int MAX_CLASSES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  count_t      cfg_wr_data,
  sact_score_if.sink  scores,
  sact_mask_if.source mask
);

  count_t      channel_count;
  logic        beat_valid;
  logic        beat_ready;
  pixel_beat_t beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CountReset;
    end else if (cfg_wr_en) begin
      channel_count <= cfg_wr_data;
    end
  end

  sact_argmax #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_argmax (
    .clk           (clk),
    .rst           (rst),
    .channel_count (channel_count),
    .scores        (scores),
    .beat_valid    (beat_valid),
    .beat          (beat),
    .beat_ready    (beat_ready)
  );

  sact_presence #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_presence (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready),
    .mask       (mask)
  );

endmodule
